[design/isort_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// isort_pkg: shared definitions for the insertion sorter
// Field widths used by the channel interfaces and the core.
// ---------------------------------------------------------------------------
package isort_pkg;

    localparam int VALUE_W = 31;

    typedef logic [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

[design/isort_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// isort_if: valid/ready channels of the insertion sorter
// Input channel carries one element; output channel carries one sorted result.
// ---------------------------------------------------------------------------
interface isort_in_if;
    import isort_pkg::*;

    logic   valid;
    logic   ready;
    value_t in_value;
    logic   in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface isort_out_if;
    import isort_pkg::*;

    logic   valid;
    logic   ready;
    value_t out_value;
    logic   out_last;
    logic   out_overflow;

    modport source (output valid, output out_value, output out_last,
                    output out_overflow, input ready);
    modport sink   (input valid, input out_value, input out_last,
                    input out_overflow, output ready);
endinterface
`default_nettype wire

[design/insertion_sorter_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// insertion_sorter_core: insertion sort over a set of 31-bit elements
// Collects a set one element per transaction and emits it in ascending order.
// ---------------------------------------------------------------------------
// Each input transaction carries one element; the element is inserted into a
// single-port store by walking down from the top and moving only strictly
// greater entries up one place, so equal elements keep arrival order. An
// insertion consists of the accept, then for each entry examined a store
// read followed by a compare and move, and finally the write of the new
// element; the walk stops on an entry that is not greater or at entry zero.
// An element dropped by a full store is accepted without a walk. The
// read-compare-write loop on the one store port sets the insertion time;
// in_ch.ready is low during the walk.
// When the element marked last has been inserted or dropped, the set is read
// back one entry at a time, by a store read and then a load into the output
// register, and the read waits for a free output register if the sink stalls,
// with out_last on the final result and out_overflow on every result of a set
// from which elements were dropped because the store held MAX_ITEMS already.
// After the final result is loaded the core takes input again while that
// result still waits in the output register. No clearing pass is needed after
// reset: only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module insertion_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  wire          clk,
    input  wire          rst_n,
    isort_in_if.sink     in_ch,
    isort_out_if.source  out_ch
);
    import isort_pkg::*;

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;  // issue read of entry below pos
    localparam logic [2:0] ST_CMP     = 3'd2;  // compare, move entry up
    localparam logic [2:0] ST_PLACE   = 3'd3;  // write new element at pos
    localparam logic [2:0] ST_EMIT_RD = 3'd4;  // read entry k for output
    localparam logic [2:0] ST_EMIT_LD = 3'd5;  // load output register

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] emit_reg, emit_next;
    value_t            val_reg, val_next;
    logic              last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    value_t            out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    // store
    value_t            mem [MAX_ITEMS];
    value_t            rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    value_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              in_fire;
    logic              out_free;
    logic              store_full;
    logic              emit_final;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign store_full  = (fill_reg == CNT_W'(MAX_ITEMS));
    assign emit_final  = ((CNT_W'(emit_reg) + CNT_W'(1)) == fill_reg);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.out_last     = out_last_reg;
    assign out_ch.out_overflow = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        emit_next      = emit_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = pos_reg - ADDR_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    val_next  = in_ch.in_value;
                    last_next = in_ch.in_last;
                    emit_next = '0;
                    if (store_full)
                    begin
                        // no room: drop element, still emit on last
                        ovf_next   = 1'b1;
                        state_next = in_ch.in_last ? ST_EMIT_RD : ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = fill_reg[ADDR_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg > val_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rd_data_reg;
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                // read only once the output register is sure to be free
                mem_raddr = emit_reg;
                if (out_free)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = rd_data_reg;
                out_last_next  = emit_final;
                out_ovf_next   = ovf_reg;
                if (emit_final)
                begin
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + ADDR_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and walk registers: no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        emit_reg      <= emit_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule
`default_nettype wire
